// ===== hw/rtl/sswg_pkg.sv =====
// Shared types and constants for the smooth start window growth block.
`timescale 1ns / 1ps
`default_nettype none
package sswg_pkg;

  localparam int unsigned WIN_W     = 32;
  localparam int unsigned SEG_W     = 16;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned DEPTH_W   = 5;
  localparam int unsigned PHASE_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam int unsigned DIV_STEPS = WIN_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [SEG_W-1:0]   SEGMENT_RST = 16'd536;
  localparam logic [CNT_W-1:0]   GRAIN_RST   = 16'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_RST   = 5'd2;

  localparam logic OP_ACK  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [PHASE_W-1:0] PH_SLOW   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SMOOTH = 2'd1;
  localparam logic [PHASE_W-1:0] PH_AVOID  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic check;
    logic mul;
    logic div_step;
    logic add;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic avoid_go;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sswg_dp.sv =====
// Datapath: window state, counters, config registers, divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module sswg_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire sswg_pkg::cmd_t                  cmd,
  output sswg_pkg::status_t                    status,
  input  wire logic                            cfg_we,
  input  wire logic [sswg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sswg_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  wire logic                            in_opcode,
  input  wire logic [sswg_pkg::SEG_W-1:0]      in_segments_acked,
  input  wire logic [sswg_pkg::WIN_W-1:0]      in_load_window,
  input  wire logic [sswg_pkg::WIN_W-1:0]      in_load_threshold,
  output logic [sswg_pkg::WIN_W-1:0]           out_window,
  output logic [sswg_pkg::PHASE_W-1:0]         out_phase
);
  import sswg_pkg::*;

  // configuration
  logic [SEG_W-1:0]   seg_r;
  logic [CNT_W-1:0]   grain_r;
  logic [DEPTH_W-1:0] depth_r;

  // architectural state
  logic [WIN_W-1:0] window_r, window_nxt;
  logic [WIN_W-1:0] thr_r, thr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] needed_r, needed_nxt;
  logic             se_r, se_nxt;

  // working registers for one request
  logic               op_r;
  logic [SEG_W-1:0]   segs_r;
  logic [WIN_W-1:0]   ld_win_r, ld_thr_r;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               rest_nz_r, rest_nz_nxt;
  logic [WIN_W-1:0]   sq_r, sq_nxt;
  logic [WIN_W-1:0]   quo_r, quo_nxt;
  logic [WIN_W-1:0]   rem_r, rem_nxt;
  logic [WIN_W-1:0]   out_window_r;
  logic [PHASE_W-1:0] out_phase_r;

  logic [WIN_W-1:0] smooth_thr;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] needed_cur;
  logic [WIN_W:0]   seg_sum;
  logic [WIN_W-1:0] seg_sat;
  logic [WIN_W:0]   div_tmp;
  logic [WIN_W:0]   div_diff;
  logic [WIN_W-1:0] quot;
  logic [WIN_W-1:0] adder;
  logic [WIN_W:0]   avoid_sum;
  logic [WIN_W-1:0] avoid_sat;
  logic [2*SEG_W-1:0] prod;

  assign smooth_thr = thr_r >> depth_r;
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign needed_cur = se_r ? needed_r : grain_r;
  assign seg_sum    = {1'b0, window_r} + {{(WIN_W + 1 - SEG_W){1'b0}}, seg_r};
  assign seg_sat    = seg_sum[WIN_W] ? '1 : seg_sum[WIN_W-1:0];

  assign prod = seg_r * seg_r;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign div_tmp  = {rem_r, quo_r[WIN_W-1]};
  assign div_diff = div_tmp - {1'b0, window_r};

  // a zero window divides by one
  assign quot      = (window_r == '0) ? sq_r : quo_r;
  assign adder     = (quot == '0) ? WIN_W'(1) : quot;
  assign avoid_sum = {1'b0, window_r} + {1'b0, adder};
  assign avoid_sat = avoid_sum[WIN_W] ? '1 : avoid_sum[WIN_W-1:0];

  assign status.is_load  = (op_r == OP_LOAD);
  assign status.avoid_go = (window_r >= thr_r) && rest_nz_r;

  always_comb begin
    window_nxt  = window_r;
    thr_nxt     = thr_r;
    cnt_nxt     = cnt_r;
    needed_nxt  = needed_r;
    se_nxt      = se_r;
    phase_nxt   = phase_r;
    rest_nz_nxt = rest_nz_r;
    sq_nxt      = sq_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;

    if (cmd.capture) begin
      phase_nxt = PH_NONE;
    end

    if (cmd.eval) begin
      if (op_r == OP_LOAD) begin
        window_nxt  = ld_win_r;
        thr_nxt     = ld_thr_r;
        rest_nz_nxt = 1'b0;
      end else if (window_r < thr_r) begin
        se_nxt     = 1'b1;
        needed_nxt = needed_cur;
        if (segs_r != '0) begin
          if (window_r <= smooth_thr) begin
            window_nxt = seg_sat;
            phase_nxt  = PH_SLOW;
          end else if (cnt_inc == needed_cur) begin
            window_nxt = seg_sat;
            needed_nxt = needed_cur + CNT_W'(1);
            cnt_nxt    = '0;
            phase_nxt  = PH_SMOOTH;
          end else begin
            cnt_nxt = cnt_inc;
          end
          rest_nz_nxt = (segs_r > SEG_W'(1));
        end else begin
          rest_nz_nxt = 1'b0;
        end
      end else begin
        rest_nz_nxt = (segs_r != '0);
      end
    end

    // leave the smooth region once the threshold is reached
    if (cmd.check && (window_r >= thr_r)) begin
      se_nxt = 1'b0;
    end

    if (cmd.mul) begin
      sq_nxt  = prod;
      quo_nxt = prod;
      rem_nxt = '0;
    end

    if (cmd.div_step) begin
      if (!div_diff[WIN_W]) begin
        rem_nxt = div_diff[WIN_W-1:0];
        quo_nxt = {quo_r[WIN_W-2:0], 1'b1};
      end else begin
        rem_nxt = div_tmp[WIN_W-1:0];
        quo_nxt = {quo_r[WIN_W-2:0], 1'b0};
      end
    end

    if (cmd.add) begin
      window_nxt = avoid_sat;
      phase_nxt  = PH_AVOID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r    <= SEGMENT_RST;
      grain_r  <= GRAIN_RST;
      depth_r  <= DEPTH_RST;
      window_r <= {{(WIN_W - SEG_W){1'b0}}, SEGMENT_RST};
      thr_r    <= '1;
      cnt_r    <= '0;
      needed_r <= '0;
      se_r     <= 1'b0;
    end else begin
      window_r <= window_nxt;
      thr_r    <= thr_nxt;
      cnt_r    <= cnt_nxt;
      needed_r <= needed_nxt;
      se_r     <= se_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SEGMENT: seg_r   <= cfg_data[SEG_W-1:0];
          REG_GRAIN:   grain_r <= cfg_data[CNT_W-1:0];
          REG_DEPTH:   depth_r <= cfg_data[DEPTH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_opcode;
      segs_r   <= in_segments_acked;
      ld_win_r <= in_load_window;
      ld_thr_r <= in_load_threshold;
    end
    if (cmd.out_load) begin
      out_window_r <= window_r;
      out_phase_r  <= phase_r;
    end
    phase_r   <= phase_nxt;
    rest_nz_r <= rest_nz_nxt;
    sq_r      <= sq_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
  end

  assign out_window = out_window_r;
  assign out_phase  = out_phase_r;

endmodule
`default_nettype wire

// ===== hw/rtl/sswg_ctrl.sv =====
// Controller: runs one request via evaluate, check, multiply, divide, add, hand-off.
`timescale 1ns / 1ps
`default_nettype none
module sswg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire sswg_pkg::status_t status,
  output sswg_pkg::cmd_t         cmd
);
  import sswg_pkg::*;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    in_stall    = 1'b1;

    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = status.is_load ? ST_DONE : ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = status.avoid_go ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        cmd.mul     = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_DONE) && slot_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_EVAL)
    else $error("accepted request did not move to evaluate");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (div_cnt_r == DIV_LAST) |=> state_r == ST_ADD)
    else $error("divider did not finish after its last step");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && slot_free |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished request not handed to the result register");

  a_load_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) && status.is_load |=> state_r == ST_DONE)
    else $error("load request entered the growth path");

endmodule
`default_nettype wire

// ===== hw/rtl/smooth_start_window_growth.sv =====
// Top level of the smooth start congestion window growth block.
//
// Usage: each request on the in_ channel is either an ACK event (in_opcode
// clear, in_segments_acked) or a load of window and threshold (in_opcode
// set, in_load_window, in_load_threshold). Each request yields exactly one
// result on the out_ channel: the window after the request and the phase
// of the growth applied. A request is taken at a clock edge with in_valid
// high and in_stall low; results move the same way with out_valid/out_stall.
// cfg_we writes segment size (index 0), grain number (1) or depth (2); the
// user must write only while the block is idle, not enforced by the block.
// One request is worked on at a time. A load goes through evaluate to result
// hand-off; an ACK through evaluate and check, and an ACK with avoidance
// growth also through multiply, the 32-step restoring divider computing
// segment_size^2 / window, and add. The next request can be taken in the
// cycle after the result register is loaded. A result held by out_stall sits
// in the output register while the next request is taken and processed; that
// request waits in its final state until the register frees. Synchronous
// reset sets the window to 536 bytes, the threshold to all ones, counters to
// zero, and defaults the configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module smooth_start_window_growth (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [sswg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sswg_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_opcode,
  input  wire logic [sswg_pkg::SEG_W-1:0]      in_segments_acked,
  input  wire logic [sswg_pkg::WIN_W-1:0]      in_load_window,
  input  wire logic [sswg_pkg::WIN_W-1:0]      in_load_threshold,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [sswg_pkg::WIN_W-1:0]           out_window,
  output logic [sswg_pkg::PHASE_W-1:0]         out_phase
);
  import sswg_pkg::*;

  cmd_t    cmd;
  status_t status;

  sswg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sswg_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_opcode         (in_opcode),
    .in_segments_acked (in_segments_acked),
    .in_load_window    (in_load_window),
    .in_load_threshold (in_load_threshold),
    .out_window        (out_window),
    .out_phase         (out_phase)
  );

endmodule
`default_nettype wire

// ===== tb/smooth_start_window_growth_test.sv =====
// Self-checking testbench for the smooth start window growth block.
`timescale 1ns / 1ps
module smooth_start_window_growth_test;
  import sswg_pkg::*;

  typedef struct packed {
    logic               op;
    logic [SEG_W-1:0]   acked;
    logic [WIN_W-1:0]   load_win;
    logic [WIN_W-1:0]   load_thr;
  } window_request_t;

  typedef struct packed {
    logic [WIN_W-1:0]   window;
    logic [PHASE_W-1:0] phase;
  } window_result_t;

  typedef struct packed {
    window_request_t req;
    logic            typed;
    window_result_t  want;
  } directed_row_t;

  localparam logic [WIN_W-1:0] ALL_ONES = '1;

  // Expected values are typed in only where they follow at a glance.
  localparam directed_row_t DIRECTED_REQUESTS [23] = '{
    '{'{OP_ACK,  16'd1,     32'd0,        32'd0},        1'b1, '{32'd1072,  PH_SLOW}},
    '{'{OP_ACK,  16'd0,     32'd0,        32'd0},        1'b1, '{32'd1072,  PH_NONE}},
    '{'{OP_LOAD, 16'hAAAA,  ALL_ONES,     ALL_ONES},     1'b1, '{ALL_ONES,  PH_NONE}},
    '{'{OP_ACK,  16'hFFFF,  32'd0,        32'd0},        1'b1, '{ALL_ONES,  PH_AVOID}},
    '{'{OP_ACK,  16'd0,     32'd0,        32'd0},        1'b1, '{ALL_ONES,  PH_NONE}},
    '{'{OP_LOAD, 16'd0,     32'd0,        32'd0},        1'b1, '{32'd0,     PH_NONE}},
    '{'{OP_ACK,  16'd1,     32'd0,        32'd0},        1'b0, '{32'd0,     PH_NONE}},
    '{'{OP_LOAD, 16'h5555,  32'd1000,     32'd2000},     1'b1, '{32'd1000,  PH_NONE}},
    '{'{OP_ACK,  16'd1,     32'd0,        32'd0},        1'b0, '{32'd0,     PH_NONE}},
    '{'{OP_ACK,  16'd1,     32'd0,        32'd0},        1'b0, '{32'd0,     PH_NONE}},
    '{'{OP_ACK,  16'd3,     32'd0,        32'd0},        1'b0, '{32'd0,     PH_NONE}},
    '{'{OP_ACK,  16'd3,     32'd0,        32'd0},        1'b0, '{32'd0,     PH_NONE}},
    '{'{OP_ACK,  16'd3,     32'd0,        32'd0},        1'b0, '{32'd0,     PH_NONE}},
    '{'{OP_LOAD, 16'd0,     32'd100,      ALL_ONES},     1'b1, '{32'd100,   PH_NONE}},
    '{'{OP_ACK,  16'hFFFF,  32'd0,        32'd0},        1'b0, '{32'd0,     PH_NONE}},
    '{'{OP_ACK,  16'h5555,  32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b0, '{32'd0,     PH_NONE}},
    '{'{OP_LOAD, 16'd0,     32'h55555555, 32'hAAAAAAAA}, 1'b1, '{32'h55555555, PH_NONE}},
    '{'{OP_ACK,  16'hAAAA,  32'd0,        32'd0},        1'b0, '{32'd0,     PH_NONE}},
    '{'{OP_ACK,  16'h5555,  32'd0,        32'd0},        1'b0, '{32'd0,     PH_NONE}},
    '{'{OP_LOAD, 16'hFFFF,  32'hAAAAAAAA, 32'h55555555}, 1'b1, '{32'hAAAAAAAA, PH_NONE}},
    '{'{OP_ACK,  16'd1,     32'd0,        32'd0},        1'b0, '{32'd0,     PH_NONE}},
    '{'{OP_ACK,  16'd0,     32'd0,        32'd0},        1'b0, '{32'd0,     PH_NONE}},
    '{'{OP_LOAD, 16'd0,     ALL_ONES,     32'd0},        1'b1, '{ALL_ONES,  PH_NONE}}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_opcode;
  logic [SEG_W-1:0]     in_segments_acked;
  logic [WIN_W-1:0]     in_load_window;
  logic [WIN_W-1:0]     in_load_threshold;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WIN_W-1:0]     out_window;
  logic [PHASE_W-1:0]   out_phase;

  smooth_start_window_growth DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_segments_acked (in_segments_acked),
    .in_load_window    (in_load_window),
    .in_load_threshold (in_load_threshold),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window        (out_window),
    .out_phase         (out_phase)
  );

  // Predicted block state and register copies.
  logic [WIN_W-1:0]   win_now   = 32'd536;
  logic [WIN_W-1:0]   thr_now   = '1;
  logic [CNT_W-1:0]   run_count = '0;
  logic [CNT_W-1:0]   run_target = '0;
  logic               in_smooth = 1'b0;
  logic [SEG_W-1:0]   cfg_seg   = SEGMENT_RST;
  logic [CNT_W-1:0]   cfg_grain = GRAIN_RST;
  logic [DEPTH_W-1:0] cfg_depth = DEPTH_RST;

  window_result_t pending_windows [$];
  logic [PHASE_W-1:0] last_phase;
  bit  quiet = 1'b0;
  int  stall_left = 0;
  int  mismatch_count = 0;
  int  results_checked = 0;
  int  requests_sent = 0;
  int  burst_requests = 0;
  int  phase_hits [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("%0t: timed out with %0d results outstanding", $time, pending_windows.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [WIN_W-1:0] add_capped(input logic [WIN_W-1:0] a,
                                                  input logic [63:0] b);
    logic [64:0] sum;
    sum = {33'b0, a} + {1'b0, b};
    return (sum > 65'h0FFFFFFFF) ? '1 : sum[WIN_W-1:0];
  endfunction

  // Advance the predicted window by one request and return the result.
  function automatic window_result_t grow_window(input window_request_t req);
    logic [SEG_W-1:0] rest;
    logic [WIN_W-1:0] knee;
    logic [63:0]      square;
    logic [63:0]      step;
    window_result_t   res;
    res.phase = PH_NONE;
    if (req.op == OP_LOAD) begin
      win_now = req.load_win;
      thr_now = req.load_thr;
    end else begin
      rest = req.acked;
      if (win_now < thr_now) begin
        knee = thr_now >> cfg_depth;
        if (!in_smooth) begin
          in_smooth  = 1'b1;
          run_target = cfg_grain;
        end
        if (req.acked != '0) begin
          if (win_now <= knee) begin
            win_now   = add_capped(win_now, {48'b0, cfg_seg});
            res.phase = PH_SLOW;
          end else begin
            run_count = run_count + 16'd1;
            if (run_count == run_target) begin
              win_now    = add_capped(win_now, {48'b0, cfg_seg});
              run_target = run_target + 16'd1;
              run_count  = '0;
              res.phase  = PH_SMOOTH;
            end
          end
          rest = req.acked - 16'd1;
        end else begin
          rest = '0;
        end
      end
      if (win_now >= thr_now) begin
        in_smooth = 1'b0;
        if (rest != '0) begin
          square = {48'b0, cfg_seg} * {48'b0, cfg_seg};
          step   = (win_now != '0) ? square / {32'b0, win_now} : square;
          if (step == '0) step = 64'd1;
          win_now   = add_capped(win_now, step);
          res.phase = PH_AVOID;
        end
      end
    end
    res.window = win_now;
    return res;
  endfunction

  function automatic int sender_gap();
    int pick;
    pick = $urandom_range(99, 0);
    if (quiet || pick < 60) return 0;
    if (pick < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic window_request_t random_ack();
    window_request_t req;
    int pick;
    pick         = $urandom_range(99, 0);
    req.op       = OP_ACK;
    req.load_win = $urandom;
    req.load_thr = $urandom;
    if (pick < 8)       req.acked = '0;
    else if (pick < 75) req.acked = SEG_W'($urandom_range(3, 1));
    else if (pick < 90) req.acked = SEG_W'($urandom_range(64, 4));
    else                req.acked = SEG_W'($urandom);
    return req;
  endfunction

  // Place the window in a chosen region relative to the new threshold.
  function automatic window_request_t load_near_threshold();
    window_request_t req;
    logic [WIN_W-1:0] knee;
    req.op    = OP_LOAD;
    req.acked = SEG_W'($urandom);
    case ($urandom_range(3, 0))
      0:       req.load_thr = $urandom;
      1:       req.load_thr = $urandom_range(32'h000FFFFF, 0);
      2:       req.load_thr = '1;
      default: req.load_thr = $urandom_range(4000, 0);
    endcase
    knee = req.load_thr >> cfg_depth;
    case ($urandom_range(4, 0))
      0:       req.load_win = $urandom_range(knee, 0);
      1:       req.load_win = $urandom_range(req.load_thr, knee);
      2:       req.load_win = $urandom_range(32'hFFFFFFFF, req.load_thr);
      3:       req.load_win = $urandom;
      default: req.load_win = 32'hFFFFFFFF - $urandom_range(70000, 0);
    endcase
    return req;
  endfunction

  task automatic offer(input window_request_t req, input logic typed,
                       input window_result_t want);
    window_result_t res;
    in_valid          <= 1'b1;
    in_opcode         <= req.op;
    in_segments_acked <= req.acked;
    in_load_window    <= req.load_win;
    in_load_threshold <= req.load_thr;
    do @(posedge clk); while (in_stall);
    res = grow_window(req);
    if (typed) res = want;
    pending_windows.push_back(res);
    last_phase = res.phase;
    requests_sent++;
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off new requests until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_config(input logic [SEG_W-1:0] seg, input logic [CNT_W-1:0] grain,
                            input logic [DEPTH_W-1:0] dep);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SEGMENT;
    cfg_data  <= seg;
    @(posedge clk);
    cfg_index <= REG_GRAIN;
    cfg_data  <= grain;
    @(posedge clk);
    cfg_index <= REG_DEPTH;
    cfg_data  <= {{(CFG_DAT_W-DEPTH_W){1'b0}}, dep};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_seg   = seg;
    cfg_grain = grain;
    cfg_depth = dep;
  endtask

  task automatic run_random(input int count, input bit no_idle);
    window_request_t req;
    int pick;
    quiet = no_idle;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 18) begin
        req = load_near_threshold();
      end else if (pick < 22) begin
        req = '{OP_LOAD, SEG_W'($urandom), WIN_W'($urandom), WIN_W'($urandom)};
      end else begin
        req = random_ack();
      end
      offer(req, 1'b0, '0);
      pause(sender_gap());
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin : hold_results
    int pick;
    pick = $urandom_range(99, 0);
    if (!rst_n || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (pick < 12) begin
      stall_left = $urandom_range(2, 0);
      out_stall <= 1'b1;
    end else if (pick < 14) begin
      stall_left = $urandom_range(45, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    window_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_windows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 20)
          $display("%0t: unexpected result window %h phase %0d", $time, out_window, out_phase);
      end else begin
        want = pending_windows.pop_front();
        results_checked++;
        phase_hits[want.phase]++;
        if (out_window !== want.window) begin
          mismatch_count++;
          if (mismatch_count <= 20)
            $display("%0t: window expected %h actual %h", $time, want.window, out_window);
        end
        if (out_phase !== want.phase) begin
          mismatch_count++;
          if (mismatch_count <= 20)
            $display("%0t: phase expected %0d actual %0d", $time, want.phase, out_phase);
        end
      end
    end
  end

  initial begin
    window_request_t req;
    int              growths;
    logic [SEG_W-1:0]   rnd_seg;
    logic [CNT_W-1:0]   rnd_grain;
    logic [DEPTH_W-1:0] rnd_depth;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_SEGMENT;
    cfg_data          <= '0;
    in_valid          <= 1'b0;
    in_opcode         <= OP_ACK;
    in_segments_acked <= '0;
    in_load_window    <= '0;
    in_load_threshold <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_REQUESTS[i]) begin
      offer(DIRECTED_REQUESTS[i].req, DIRECTED_REQUESTS[i].typed, DIRECTED_REQUESTS[i].want);
      pause(sender_gap());
    end

    // Smooth run: the ACK run needed for a growth rises by one after each growth.
    drain();
    set_config(16'd1, 16'd3, 5'd31);
    quiet = 1'b1;
    offer('{OP_LOAD, 16'd0, 32'd5, 32'd5}, 1'b0, '0);
    offer('{OP_ACK, 16'd0, 32'd0, 32'd0}, 1'b0, '0);
    offer('{OP_LOAD, 16'd0, 32'd1000, ALL_ONES}, 1'b0, '0);
    growths = 0;
    while (growths < 2 && burst_requests < 40) begin
      req = '{OP_ACK, SEG_W'($urandom_range(65535, 1)), WIN_W'($urandom), WIN_W'($urandom)};
      offer(req, 1'b0, '0);
      burst_requests++;
      if (last_phase == PH_SMOOTH) growths++;
    end
    quiet = 1'b0;

    drain();
    set_config(16'd1, 16'd1, 5'd0);
    run_random(115, 1'b0);
    drain();
    set_config(16'hFFFF, 16'hFFFF, 5'd31);
    run_random(115, 1'b0);
    drain();
    set_config(16'd1460, 16'd3, 5'd4);
    run_random(115, 1'b1);
    drain();
    rnd_seg   = SEG_W'($urandom_range(65535, 1));
    rnd_grain = CNT_W'($urandom_range(65535, 1));
    rnd_depth = DEPTH_W'($urandom);
    set_config(rnd_seg, rnd_grain, rnd_depth);
    run_random(115, 1'b0);
    drain();
    set_config(16'hFFFF, 16'd1, 5'd0);
    run_random(115, 1'b0);
    drain();
    set_config(SEGMENT_RST, GRAIN_RST, DEPTH_RST);
    run_random(115, 1'b0);

    drain();
    if (pending_windows.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_windows.size());
    end
    $display("Ran %0d requests (%0d in the smooth run), checked %0d results",
             requests_sent, burst_requests, results_checked);
    $display("Results by phase: slow %0d, smooth %0d, avoidance %0d, none %0d",
             phase_hits[0], phase_hits[1], phase_hits[2], phase_hits[3]);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sswg_pkg.sv
hw/rtl/sswg_dp.sv
hw/rtl/sswg_ctrl.sv
hw/rtl/smooth_start_window_growth.sv
tb/smooth_start_window_growth_test.sv
